[rtl/pvm_pkg.sv]
`timescale 1ns / 1ps

package pvm_pkg;

    localparam int VOICES           = 32;
    localparam int VOICE_BITS       = $clog2(VOICES);
    localparam int VCNT_BITS        = $clog2(VOICES + 1);
    localparam int SAMPLE_ADDR_BITS = 20;
    localparam int MEM_DEPTH        = 1 << SAMPLE_ADDR_BITS;

    localparam int POS_W   = 36;
    localparam int STEP_W  = 32;
    localparam int BASE_W  = 20;
    localparam int LEN_W   = 21;
    localparam int RATE_W  = 16;
    localparam int GAIN_W  = 7;
    localparam int ORATE_W = 17;
    localparam int ACC_W   = 24;

    // step = (rate * pitch << 9) / output_rate
    localparam int NUM_W   = RATE_W + 8 + 9;
    localparam int DEN_W   = ORATE_W;
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    localparam logic [ORATE_W-1:0] ORATE_RESET = ORATE_W'(11025);

    localparam logic [2:0] OP_MIX    = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;

    // reciprocal of 127 for mix products below 2^23
    localparam logic [18:0] RECIP_MIX = 19'd264208;
    localparam int          RECIP_MIX_SH = 25;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [STEP_W-1:0] step;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [RATE_W-1:0] rate;
        logic [GAIN_W-1:0] gl;
        logic [GAIN_W-1:0] gr;
    } t_voice;

    // min(127, x / 127) for x below 2^15
    function automatic logic [GAIN_W-1:0] gain_div(input logic [14:0] x);
        logic [23:0] prod;
        logic [8:0]  q0;
        logic [15:0] rem;
        logic [8:0]  q;
        begin
            prod = {9'd0, x} * 24'd258;
            q0   = prod[23:15];
            rem  = {1'b0, x} - 16'({7'd0, q0} * 16'd127);
            q    = (rem >= 16'd127) ? q0 + 9'd1 : q0;
            gain_div = (q > 9'd127) ? GAIN_W'(127) : q[GAIN_W-1:0];
        end
    endfunction

endpackage

[rtl/pvm_div.sv]
`timescale 1ns / 1ps

module pvm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pvm_pkg::NUM_W-1:0]  i_num,
    input  logic [pvm_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [pvm_pkg::NUM_W-1:0]  o_quot
);

    logic                        r_busy;
    logic                        r_done;
    logic [pvm_pkg::DCNT_W-1:0]  r_cnt;
    logic [pvm_pkg::DEN_W:0]     r_rem;
    logic [pvm_pkg::NUM_W-1:0]   r_q;
    logic [pvm_pkg::DEN_W-1:0]   r_den;
    logic [pvm_pkg::DEN_W:0]     trial;
    logic                        fits;

    // shift in one numerator bit, subtract when it fits
    assign trial = {r_rem[pvm_pkg::DEN_W-1:0], r_q[pvm_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pvm_pkg::DCNT_W'(pvm_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pvm_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? trial - {1'b0, r_den} : trial;
            r_q   <= {r_q[pvm_pkg::NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/pcm_voice_mixer.sv]
`timescale 1ns / 1ps
// 32-voice mixer for unsigned 8-bit PCM held in a 1 MiB sample memory.
// Input channel (i_in_valid / o_in_ready) carries one command per transfer:
// mix frame, start voice, update voice, stop voice or write a sample byte.
// Output channel (o_out_valid / i_out_ready) carries one stereo frame and the
// active voice mask for each mix command; other commands give no output.
// The config channel (i_cfg_valid / o_cfg_ready) writes the output rate and
// is always ready.
// Timing: write, stop and unused codes are handled in the idle state. Start
// and update pass the prepare, divider start and divide states, the last
// set by the bit-serial step divider (33 steps). A mix walks the voice memory
// one voice per cycle through a voice read, sample read, multiply, reciprocal
// and accumulate pipeline; its frame is ready later when one of the last
// voices plays. The frame sits in an output register; the next command is
// taken while it waits, and a following mix holds at its end until the
// register frees.
// Reset clears voice activity, the control state and sets the output rate to
// 11025; the sample memory is undefined until written.

module pcm_voice_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pvm_pkg::ORATE_W-1:0]         i_output_rate,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_opcode,
    input  logic [4:0]                          i_voice,
    input  logic [19:0]                         i_address,
    input  logic [20:0]                         i_length,
    input  logic [15:0]                         i_sample_rate,
    input  logic [7:0]                          i_volume,
    input  logic [7:0]                          i_separation,
    input  logic [7:0]                          i_pitch,
    input  logic [7:0]                          i_data_byte,
    input  logic signed [15:0]                  i_music_left,
    input  logic signed [15:0]                  i_music_right,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [15:0]                  o_left_out,
    output logic signed [15:0]                  o_right_out,
    output logic [31:0]                         o_active_mask
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DGO  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MIX  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int VB = pvm_pkg::VOICE_BITS;
    localparam int AB = pvm_pkg::SAMPLE_ADDR_BITS;

    logic [2:0]                    r_state;
    logic [pvm_pkg::ORATE_W-1:0]   r_orate;
    logic [pvm_pkg::VOICES-1:0]    r_active;
    logic                          in_xfer;
    logic                          out_xfer;

    // memories
    pvm_pkg::t_voice               r_vmem [pvm_pkg::VOICES];
    pvm_pkg::t_voice               r_vrd;
    logic [VB-1:0]                 vrd_addr;
    logic                          vwe;
    logic [VB-1:0]                 vwr_addr;
    pvm_pkg::t_voice               vwr_data;
    logic [7:0]                    r_smem [pvm_pkg::MEM_DEPTH];
    logic [7:0]                    r_smp;
    logic [AB-1:0]                 srd_addr;

    // command latch
    logic                          r_is_start;
    logic [VB-1:0]                 r_voice;
    logic [19:0]                   r_base;
    logic [20:0]                   r_len;
    logic [15:0]                   r_rate_in;
    logic [7:0]                    r_vol;
    logic [7:0]                    r_sep;
    logic [7:0]                    r_pit;

    // step and gain path
    pvm_pkg::t_voice               r_ent;
    logic [pvm_pkg::NUM_W-1:0]     r_num;
    logic [pvm_pkg::GAIN_W-1:0]    r_gl;
    logic [pvm_pkg::GAIN_W-1:0]    r_gr;
    logic [pvm_pkg::STEP_W-1:0]    step_sat;
    logic                          div_done;
    logic [pvm_pkg::NUM_W-1:0]     div_quot;
    logic [pvm_pkg::DEN_W-1:0]     den;
    logic [6:0]                    vol_sat;
    logic [7:0]                    pit_min;
    logic [15:0]                   prep_rate;
    logic [23:0]                   rate_prod;

    // mix pipeline
    logic [pvm_pkg::VCNT_BITS-1:0] r_vidx;
    logic                          r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [VB-1:0]                 r_s1_idx;
    logic [pvm_pkg::GAIN_W-1:0]    r_s2_gl, r_s2_gr;
    logic [22:0]                   r_s3_ml, r_s3_mr, r_s4_ml, r_s4_mr;
    logic                          r_s3_nl, r_s3_nr, r_s4_nl, r_s4_nr;
    logic [16:0]                   r_s4_ql, r_s4_qr;
    logic signed [pvm_pkg::ACC_W-1:0] r_accl, r_accr;
    logic [19:0]                   s1_idx;
    logic                          s1_play;
    logic signed [8:0]             s2_d;
    logic signed [15:0]            s2_pl, s2_pr;
    logic [41:0]                   s3_prl, s3_prr;
    logic signed [pvm_pkg::ACC_W-1:0] s4_tl, s4_tr;

    // output register
    logic                          r_out_valid;
    logic signed [15:0]            r_left, r_right;
    logic [31:0]                   r_mask;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // output rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orate <= pvm_pkg::ORATE_RESET;
        end else if (i_cfg_valid) begin
            r_orate <= i_output_rate;
        end
    end

    // sample memory: write on transfer, read from mix stage one
    assign srd_addr = AB'(r_vrd.base + r_vrd.pos[pvm_pkg::POS_W-1:16]);

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_opcode == pvm_pkg::OP_WRITE) begin
            r_smem[i_address[AB-1:0]] <= i_data_byte;
        end
        r_smp <= r_smem[srd_addr];
    end

    // voice memory
    assign vrd_addr = (r_state == ST_IDLE) ? i_voice[VB-1:0] : r_vidx[VB-1:0];

    always_ff @(posedge i_clk) begin
        if (vwe) begin
            r_vmem[vwr_addr] <= vwr_data;
        end
        r_vrd <= r_vmem[vrd_addr];
    end

    // step and gain arithmetic
    assign vol_sat   = (r_vol > 8'd127) ? 7'd127 : r_vol[6:0];
    assign pit_min   = (r_pit == 8'd0) ? 8'd1 : r_pit;
    assign prep_rate = r_is_start ? r_rate_in : r_vrd.rate;
    assign rate_prod = {8'd0, prep_rate} * {16'd0, pit_min};
    assign den       = (r_orate == '0) ? pvm_pkg::DEN_W'(1) : r_orate;
    assign step_sat  = (div_quot[pvm_pkg::NUM_W-1:pvm_pkg::STEP_W] != '0) ? '1 :
                       (div_quot == '0) ? pvm_pkg::STEP_W'(1) :
                       div_quot[pvm_pkg::STEP_W-1:0];

    pvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DGO),
        .i_num   (r_num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // latch command fields, prepare numerator and gains
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_is_start <= (i_opcode == pvm_pkg::OP_START);
            r_voice    <= i_voice[VB-1:0];
            r_base     <= i_address;
            r_len      <= i_length;
            r_rate_in  <= i_sample_rate;
            r_vol      <= i_volume;
            r_sep      <= i_separation;
            r_pit      <= i_pitch;
        end
        if (r_state == ST_PREP) begin
            r_ent <= r_vrd;
            r_num <= {rate_prod, 9'd0};
            r_gl  <= pvm_pkg::gain_div(15'({8'd0, vol_sat} * {7'd0, 8'd255 - r_sep}));
            r_gr  <= pvm_pkg::gain_div(15'({8'd0, vol_sat} * {7'd0, r_sep}));
        end
    end

    // mix stage one: end check, sample address, position write back
    assign s1_idx  = r_vrd.pos[pvm_pkg::POS_W-1:16];
    assign s1_play = r_s1_v && r_active[r_s1_idx] && ({1'b0, s1_idx} < r_vrd.len);

    // voice memory write: command write back or position advance
    always_comb begin
        vwe      = 1'b0;
        vwr_addr = r_s1_idx;
        vwr_data = r_vrd;
        if (r_state == ST_DIV && div_done) begin
            vwe      = 1'b1;
            vwr_addr = r_voice;
            if (r_is_start) begin
                vwr_data.pos  = '0;
                vwr_data.base = r_base;
                vwr_data.len  = r_len;
                vwr_data.rate = r_rate_in;
            end else begin
                vwr_data = r_ent;
            end
            vwr_data.step = step_sat;
            vwr_data.gl   = r_gl;
            vwr_data.gr   = r_gr;
        end else if (s1_play) begin
            vwe          = 1'b1;
            vwr_data.pos = r_vrd.pos + {4'd0, r_vrd.step};
        end
    end

    // mix stage two: signed sample times gain, magnitude scaled by 256
    assign s2_d  = $signed({1'b0, r_smp}) - 9'sd128;
    assign s2_pl = 16'(s2_d * $signed({1'b0, r_s2_gl}));
    assign s2_pr = 16'(s2_d * $signed({1'b0, r_s2_gr}));

    // mix stage three: reciprocal estimate of the quotient by 127
    assign s3_prl = {19'd0, r_s3_ml} * {23'd0, pvm_pkg::RECIP_MIX};
    assign s3_prr = {19'd0, r_s3_mr} * {23'd0, pvm_pkg::RECIP_MIX};

    // mix stage four: correct by one, restore sign
    function automatic logic signed [pvm_pkg::ACC_W-1:0] fix_q(
        input logic [22:0] m, input logic [16:0] q0, input logic neg);
        logic [23:0] rem;
        logic [16:0] q;
        begin
            rem = {1'b0, m} - 24'({7'd0, q0} * 24'd127);
            q   = (rem >= 24'd127) ? q0 + 17'd1 : q0;
            fix_q = neg ? -$signed({7'd0, q}) : $signed({7'd0, q});
        end
    endfunction

    assign s4_tl = fix_q(r_s4_ml, r_s4_ql, r_s4_nl);
    assign s4_tr = fix_q(r_s4_mr, r_s4_qr, r_s4_nr);

    // mix pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == ST_MIX) && (r_vidx != pvm_pkg::VCNT_BITS'(pvm_pkg::VOICES));
            r_s2_v <= s1_play;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_vidx[VB-1:0];
        r_s2_gl  <= r_vrd.gl;
        r_s2_gr  <= r_vrd.gr;
        r_s3_nl  <= s2_pl[15];
        r_s3_nr  <= s2_pr[15];
        r_s3_ml  <= {15'(s2_pl[15] ? -s2_pl : s2_pl), 8'd0};
        r_s3_mr  <= {15'(s2_pr[15] ? -s2_pr : s2_pr), 8'd0};
        r_s4_nl  <= r_s3_nl;
        r_s4_nr  <= r_s3_nr;
        r_s4_ml  <= r_s3_ml;
        r_s4_mr  <= r_s3_mr;
        r_s4_ql  <= s3_prl[pvm_pkg::RECIP_MIX_SH +: 17];
        r_s4_qr  <= s3_prr[pvm_pkg::RECIP_MIX_SH +: 17];
        if (in_xfer && i_opcode == pvm_pkg::OP_MIX) begin
            r_accl <= pvm_pkg::ACC_W'(i_music_left);
            r_accr <= pvm_pkg::ACC_W'(i_music_right);
        end else if (r_s4_v) begin
            r_accl <= r_accl + s4_tl;
            r_accr <= r_accr + s4_tr;
        end
    end

    // sequencer, voice counter and activity bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_vidx   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (i_opcode)
                            pvm_pkg::OP_MIX: begin
                                r_vidx  <= '0;
                                r_state <= ST_MIX;
                            end
                            pvm_pkg::OP_START, pvm_pkg::OP_UPDATE: begin
                                if ({1'b0, i_voice} < 6'(pvm_pkg::VOICES)) begin
                                    r_state <= ST_PREP;
                                end
                            end
                            pvm_pkg::OP_STOP: begin
                                if ({1'b0, i_voice} < 6'(pvm_pkg::VOICES)) begin
                                    r_active[i_voice[VB-1:0]] <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_PREP: r_state <= ST_DGO;
                ST_DGO:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        if (r_is_start) begin
                            r_active[r_voice] <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_MIX: begin
                    if (r_vidx != pvm_pkg::VCNT_BITS'(pvm_pkg::VOICES)) begin
                        r_vidx <= r_vidx + 1'b1;
                    end else if (!r_s1_v && !r_s2_v && !r_s3_v && !r_s4_v) begin
                        r_state <= ST_FIN;
                    end
                    // drop voices that ran past their length
                    if (r_s1_v && r_active[r_s1_idx] && !s1_play) begin
                        r_active[r_s1_idx] <= 1'b0;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register: load the clipped frame, hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && (!r_out_valid || i_out_ready)) begin
            r_left  <= (r_accl > 24'sd32767) ? 16'sh7fff :
                       (r_accl < -24'sd32768) ? -16'sh8000 : r_accl[15:0];
            r_right <= (r_accr > 24'sd32767) ? 16'sh7fff :
                       (r_accr < -24'sd32768) ? -16'sh8000 : r_accr[15:0];
            r_mask  <= 32'(r_active);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_out    = r_left;
    assign o_right_out   = r_right;
    assign o_active_mask = r_mask;

    // a command is taken only with the mix pipeline drained
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_s1_v && !r_s2_v && !r_s3_v && !r_s4_v)
        else $error("command taken with mix pipeline busy");

    // the divider reports only while its result is awaited
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider result outside divide state");

    // a finished frame is never overwritten before its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_left) && $stable(r_mask))
        else $error("pending frame lost");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_MID   = 3'd6;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
    localparam int         WIN_BASE      = 20'hFFF00;   // written window, wraps past zero
    localparam int         WIN_SIZE      = 512;
    localparam int         PHASE_ITEMS   = 230;
    localparam int         SETTLE_CYC    = 60;
    localparam int         LONG_HOLD_CYC = 400;
    localparam longint     CYCLE_LIMIT   = 1500000;

    typedef struct {
        logic [2:0]         op;
        logic [4:0]         v;
        logic [19:0]        addr;
        logic [20:0]        len;
        logic [15:0]        rate;
        logic [7:0]         vol;
        logic [7:0]         sep;
        logic [7:0]         pit;
        logic [7:0]         data;
        logic signed [15:0] ml;
        logic signed [15:0] mr;
        bit                 fixed;
        logic signed [15:0] fl;
        logic signed [15:0] fr;
        logic [31:0]        fm;
    } t_cmd;

    typedef struct {
        logic signed [15:0] l;
        logic signed [15:0] r;
        logic [31:0]        m;
    } t_frame;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [pvm_pkg::ORATE_W-1:0] i_output_rate;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [2:0]                  i_opcode;
    logic [4:0]                  i_voice;
    logic [19:0]                 i_address;
    logic [20:0]                 i_length;
    logic [15:0]                 i_sample_rate;
    logic [7:0]                  i_volume;
    logic [7:0]                  i_separation;
    logic [7:0]                  i_pitch;
    logic [7:0]                  i_data_byte;
    logic signed [15:0]          i_music_left;
    logic signed [15:0]          i_music_right;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [15:0]          o_left_out;
    logic signed [15:0]          o_right_out;
    logic [31:0]                 o_active_mask;

    pcm_voice_mixer dut (.*);

    // predictor state
    logic [7:0]                  smem [int];
    bit                          v_act  [pvm_pkg::VOICES];
    logic [pvm_pkg::POS_W-1:0]   v_pos  [pvm_pkg::VOICES];
    logic [pvm_pkg::STEP_W-1:0]  v_step [pvm_pkg::VOICES];
    logic [pvm_pkg::BASE_W-1:0]  v_base [pvm_pkg::VOICES];
    logic [pvm_pkg::LEN_W-1:0]   v_len  [pvm_pkg::VOICES];
    logic [pvm_pkg::RATE_W-1:0]  v_rate [pvm_pkg::VOICES];
    logic [pvm_pkg::GAIN_W-1:0]  v_gl   [pvm_pkg::VOICES];
    logic [pvm_pkg::GAIN_W-1:0]  v_gr   [pvm_pkg::VOICES];
    logic [pvm_pkg::ORATE_W-1:0] orate;

    t_frame pending_frames[$];
    t_cmd   cur;
    t_cmd   rows[$];
    int     err_cnt;
    longint cycles;
    bit     calm;
    bit     long_hold_req;
    int     hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [pvm_pkg::STEP_W-1:0] calc_step(logic [15:0] rate,
                                                             logic [7:0] p);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        num = (longint'(rate) * longint'(p)) << 16;
        den = (orate == 0 ? 64'd1 : longint'(orate)) * 128;
        q = num / den;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        if (q == 0) q = 1;
        return q[31:0];
    endfunction

    function automatic void set_voice_params(int v, logic [7:0] vol, logic [7:0] sep,
                                             logic [7:0] pit);
        int vv;
        int pp;
        int l;
        int r;
        vv = (vol > 127) ? 127 : vol;
        pp = (pit < 1) ? 1 : pit;
        l = vv * (255 - sep) / 127;
        r = vv * sep / 127;
        v_gl[v] = (l > 127) ? 7'd127 : l[6:0];
        v_gr[v] = (r > 127) ? 7'd127 : r[6:0];
        v_step[v] = calc_step(v_rate[v], pp[7:0]);
    endfunction

    function automatic logic signed [15:0] clip16(int x);
        if (x > 32767) return 16'sh7FFF;
        if (x < -32768) return 16'sh8000;
        return x[15:0];
    endfunction

    // walk all voices for one frame
    function automatic t_frame mix_frame(logic signed [15:0] ml, logic signed [15:0] mr);
        t_frame f;
        int l;
        int r;
        int s;
        int unsigned idx;
        logic [19:0] ad;
        l = ml;
        r = mr;
        f.m = '0;
        for (int i = 0; i < pvm_pkg::VOICES; i++) begin
            if (!v_act[i]) continue;
            idx = 32'(v_pos[i][35:16]);
            if (idx >= v_len[i]) begin
                v_act[i] = 0;
                continue;
            end
            ad = v_base[i] + idx[19:0];
            s = ((smem.exists(ad) ? int'(smem[ad]) : 0) - 128) * 256;
            l += s * int'(v_gl[i]) / 127;
            r += s * int'(v_gr[i]) / 127;
            v_pos[i] = v_pos[i] + pvm_pkg::POS_W'(v_step[i]);
            f.m[i] = 1'b1;
        end
        f.l = clip16(l);
        f.r = clip16(r);
        return f;
    endfunction

    // track transfers and check frames
    always @(posedge i_clk) begin
        t_frame pf;
        t_frame got;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) orate = i_output_rate;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            case (i_opcode)
                pvm_pkg::OP_WRITE: smem[i_address] = i_data_byte;
                pvm_pkg::OP_START: begin
                    v_base[i_voice] = i_address;
                    v_len[i_voice]  = i_length;
                    v_rate[i_voice] = i_sample_rate;
                    v_pos[i_voice]  = '0;
                    set_voice_params(i_voice, i_volume, i_separation, i_pitch);
                    v_act[i_voice]  = 1;
                end
                pvm_pkg::OP_UPDATE: set_voice_params(i_voice, i_volume, i_separation, i_pitch);
                pvm_pkg::OP_STOP: v_act[i_voice] = 0;
                pvm_pkg::OP_MIX: begin
                    pf = mix_frame(i_music_left, i_music_right);
                    if (cur.fixed) begin
                        pf.l = cur.fl;
                        pf.r = cur.fr;
                        pf.m = cur.fm;
                    end
                    pending_frames.push_back(pf);
                end
                default: ;
            endcase
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.l = o_left_out;
            got.r = o_right_out;
            got.m = o_active_mask;
            if (pending_frames.size() == 0) begin
                $display("%0t unexpected frame: actual %h %h %h", $realtime,
                         got.l, got.r, got.m);
                err_cnt++;
            end else begin
                pf = pending_frames.pop_front();
                if (got.l !== pf.l) begin
                    $display("%0t left: expected %h actual %h", $realtime, pf.l, got.l);
                    err_cnt++;
                end
                if (got.r !== pf.r) begin
                    $display("%0t right: expected %h actual %h", $realtime, pf.r, got.r);
                    err_cnt++;
                end
                if (got.m !== pf.m) begin
                    $display("%0t mask: expected %h actual %h", $realtime, pf.m, got.m);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: random holds, one long hold on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = LONG_HOLD_CYC - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left = int'($urandom_range(1, 5)) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.op   = pvm_pkg::OP_MIX;
        c.v    = 5'($urandom);
        c.addr = 20'($urandom);
        c.len  = 21'($urandom);
        c.rate = 16'($urandom);
        c.vol  = 8'($urandom);
        c.sep  = 8'($urandom);
        c.pit  = 8'($urandom);
        c.data = 8'($urandom);
        c.ml   = 16'($urandom);
        c.mr   = 16'($urandom);
        if ($urandom_range(0, 9) == 0) c.ml = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if ($urandom_range(0, 9) == 0) c.mr = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        c.fixed = 0;
        c.fl = '0;
        c.fr = '0;
        c.fm = '0;
        return c;
    endfunction

    function automatic t_cmd row(logic [2:0] op, int v, int addr, int len, int rate,
                                 int vol, int sep, int pit, int data, int ml, int mr,
                                 bit fixed = 0, int fl = 0, int fr = 0, int fm = 0);
        t_cmd c;
        c.op = op; c.v = 5'(v); c.addr = 20'(addr); c.len = 21'(len); c.rate = 16'(rate);
        c.vol = 8'(vol); c.sep = 8'(sep); c.pit = 8'(pit); c.data = 8'(data);
        c.ml = 16'(ml); c.mr = 16'(mr);
        c.fixed = fixed; c.fl = 16'(fl); c.fr = 16'(fr); c.fm = 32'(fm);
        return c;
    endfunction

    // present one command and hold it until the transfer
    task automatic send(t_cmd c);
        cur           <= c;
        i_in_valid    <= 1'b1;
        i_opcode      <= c.op;
        i_voice       <= c.v;
        i_address     <= c.addr;
        i_length      <= c.len;
        i_sample_rate <= c.rate;
        i_volume      <= c.vol;
        i_separation  <= c.sep;
        i_pitch       <= c.pit;
        i_data_byte   <= c.data;
        i_music_left  <= c.ml;
        i_music_right <= c.mr;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // wait for every frame, then let start/update work finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_rate(logic [pvm_pkg::ORATE_W-1:0] r);
        i_cfg_valid   <= 1'b1;
        i_output_rate <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one random command or short sequence
    task automatic random_item();
        t_cmd c;
        int k;
        int off;
        c = rand_cmd();
        k = $urandom_range(0, 99);
        if (k < 40) begin
            c.op = pvm_pkg::OP_MIX;
            send(c);
        end else if (k < 55) begin
            // start inside the written window
            off = $urandom_range(0, WIN_SIZE - 1);
            c.op = pvm_pkg::OP_START;
            c.addr = 20'(WIN_BASE + off);
            c.len = $urandom_range(0, 3) == 0 ? 21'($urandom_range(0, WIN_SIZE - off))
                                              : 21'($urandom_range(0, (WIN_SIZE - off) / 8));
            send(c);
        end else if (k < 65) begin
            c.op = pvm_pkg::OP_UPDATE;
            send(c);
        end else if (k < 70) begin
            c.op = pvm_pkg::OP_STOP;
            send(c);
        end else if (k < 82) begin
            c.op = pvm_pkg::OP_WRITE;
            if ($urandom_range(0, 1)) c.addr = 20'(WIN_BASE + $urandom_range(0, WIN_SIZE - 1));
            send(c);
        end else if (k < 90) begin
            // arbitrary start, silenced before any frame can read it
            c.op = pvm_pkg::OP_START;
            send(c);
            c = rand_cmd();
            c.op = pvm_pkg::OP_STOP;
            c.v = cur.v;
            send(c);
        end else begin
            c.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            send(c);
        end
    endtask

    initial begin
        logic [pvm_pkg::ORATE_W-1:0] rates [6];
        t_cmd c;
        err_cnt = 0;
        cycles = 0;
        calm = 0;
        long_hold_req = 0;
        hold_left = 0;
        orate = pvm_pkg::ORATE_RESET;
        for (int i = 0; i < pvm_pkg::VOICES; i++) begin
            v_act[i] = 0; v_pos[i] = '0; v_step[i] = '0; v_base[i] = '0;
            v_len[i] = '0; v_rate[i] = '0; v_gl[i] = '0; v_gr[i] = '0;
        end
        cur = rand_cmd();
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_output_rate = '0;
        i_in_valid = 1'b0;
        i_opcode = pvm_pkg::OP_MIX;
        i_voice = '0;
        i_address = '0;
        i_length = '0;
        i_sample_rate = '0;
        i_volume = '0;
        i_separation = '0;
        i_pitch = '0;
        i_data_byte = '0;
        i_music_left = '0;
        i_music_right = '0;
        i_out_ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 32767, -32768,
                           1, 32767, -32768, 0));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, -32768, 32767,
                           1, -32768, 32767, 0));
        rows.push_back(row(pvm_pkg::OP_WRITE, 0, 20'hFFFFF, 0, 0, 0, 0, 0, 8'hFF, 0, 0));
        rows.push_back(row(pvm_pkg::OP_WRITE, 0, 20'h00000, 0, 0, 0, 0, 0, 8'h00, 0, 0));
        // full left, one sample per frame, wrapping past the top of memory
        rows.push_back(row(pvm_pkg::OP_START, 0, 20'hFFFFF, 2, 11025, 255, 0, 128, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 32767, 100,
                           1, 32767, 100, 1));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, -32768, -5,
                           1, -32768, -5, 1));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        // zero length with pitch zero: ends at the next frame
        rows.push_back(row(pvm_pkg::OP_START, 31, 20'h12345, 0, 65535, 127, 255, 0, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 7, 8, 1, 7, 8, 0));
        rows.push_back(row(pvm_pkg::OP_UPDATE, 5, 0, 0, 0, 200, 128, 255, 0, 0, 0));
        rows.push_back(row(OP_RSVD_FIRST, 6, 20'hFFFFF, 21'h1FFFFF, 65535, 255, 255, 255,
                           255, -1, -1));
        rows.push_back(row(OP_RSVD_MID, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(OP_RSVD_LAST, 31, 20'hAAAAA, 21'h155555, 16'h5555, 8'hAA,
                           8'h55, 8'hAA, 8'h55, 16'h5555, 16'hAAAA));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 3, 4, 1, 3, 4, 0));
        rows.push_back(row(pvm_pkg::OP_START, 1, 20'hFFFFF, 21'h1FFFFF, 1, 0, 255, 1,
                           0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_STOP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_START, 2, 0, 1, 65535, 127, 128, 255, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_UPDATE, 5, 0, 0, 0, 127, 0, 128, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_START, 3, 20'hFFFFF, 2, 22050, 64, 64, 128, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_STOP, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(pvm_pkg::OP_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 1, 1, 2, 0));
        foreach (rows[i]) send(rows[i]);

        // fill the sample window
        for (int a = 0; a < WIN_SIZE; a++) begin
            c = rand_cmd();
            c.op = pvm_pkg::OP_WRITE;
            c.addr = 20'(WIN_BASE + a);
            send(c);
        end

        rates[0] = pvm_pkg::ORATE_RESET;
        rates[1] = 17'd8000;
        rates[2] = 17'd96000;
        rates[3] = 17'd0;
        rates[4] = 17'h1FFFF;
        rates[5] = 17'($urandom_range(8000, 96000));
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_rate(rates[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) calm = 1;
                if (ph == 1 && n == 50) long_hold_req = 1;
                if (ph == 2 && n == 100) begin
                    i_in_valid <= 1'b0;
                    while (pending_frames.size() != 0) @(negedge i_clk);
                end
                random_item();
            end
        end

        // drain
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (pending_frames.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
